/* hdl/fqop_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqop_pkg: shared types and codes for the frame queue
// Entry layout, operation, policy and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package fqop_pkg;

  // Number of entry cells in the queue.
  localparam int DEPTH = 8;

  // Width of the entry count (holds zero up to DEPTH).
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Width of a cell index.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths.
  localparam int CAP_W    = 4;
  localparam int POL_W    = 2;
  localparam int OUTCNT_W = 4;
  localparam int TS_W     = 63;

  typedef logic [OUTCNT_W-1:0] outcnt_t;

  // Requested operation.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Overflow handling when the queue is full; the unused code drops the oldest.
  typedef enum logic [POL_W-1:0] {
    POL_DROP_OLDEST  = 2'd0,
    POL_DROP_NEW     = 2'd1,
    POL_DROP_BACKLOG = 2'd2,
    POL_SPARE        = 2'd3
  } policy_t;

  // Result status.
  typedef enum logic [3:0] {
    ST_QUEUED          = 4'd0,
    ST_DROPPED_NEW     = 4'd1,
    ST_DROPPED_OLDEST  = 4'd2,
    ST_DROPPED_BACKLOG = 4'd3,
    ST_BAD_FRAME       = 4'd4,
    ST_BAD_CONFIG      = 4'd5,
    ST_POPPED          = 4'd6,
    ST_EMPTY           = 4'd7,
    ST_CLEARED         = 4'd8,
    ST_DRAINED         = 4'd9
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_POLICY   = 1'b1
  } reg_idx_t;

  // One queued frame descriptor.
  typedef struct packed {
    logic [31:0]     handle;
    logic [15:0]     width;
    logic [15:0]     height;
    logic [TS_W-1:0] timestamp;
    logic [63:0]     queued_time;
  } entry_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* hdl/fqop_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqop_cell: one storage cell of the frame queue
// Holds one entry; loads a new frame or takes the entry of the cell behind it.
// ----------------------------------------------------------------------------
module fqop_cell (
  input  logic               clk,
  input  fqop_pkg::cell_ctrl_t ctrl,
  input  fqop_pkg::entry_t   nbr_entry,
  input  fqop_pkg::entry_t   load_entry,
  output fqop_pkg::entry_t   entry
);
  import fqop_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // A load wins over a shift, since the loaded cell is the new tail.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = load_entry;
    end else if (ctrl.shift) begin
      entry_nxt = nbr_entry;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* hdl/frame_queue_with_overflow_policy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_queue_with_overflow_policy: bounded frame descriptor queue
// Row of entry cells with the head in cell zero, plus the queue controller.
// ----------------------------------------------------------------------------
// The queue takes one input beat at a time. A push, pop or clear updates the
// queue in the cycle it is accepted, registers its single result as pending
// and then places it in the output register. A drain produces one result
// beat per stored entry, or a single beat when the queue is empty, one a
// cycle while the output is taken, because each beat moves the row of cells
// one place towards the head. The next input beat is taken once the last
// result of the current one has been placed in the output register;
// back-pressure on the output holds the pending result until the slot frees.
// Configuration writes are always taken and apply to the next push.
// ----------------------------------------------------------------------------
module frame_queue_with_overflow_policy (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [3:0]             cfg_data,
  // Input beats
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_operation,
  input  logic [31:0]            in_frame_handle,
  input  logic [15:0]            in_frame_width,
  input  logic [15:0]            in_frame_height,
  input  logic signed [63:0]     in_frame_timestamp,
  input  logic [63:0]            in_queued_time,
  // Result beats
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_status,
  output logic [3:0]             out_dropped_count,
  output logic                   out_frame_valid,
  output logic [31:0]            out_handle,
  output logic [15:0]            out_width,
  output logic [15:0]            out_height,
  output logic [62:0]            out_timestamp,
  output logic [63:0]            out_queued_time,
  output logic [3:0]             out_depth,
  output logic [63:0]            out_oldest_age,
  output logic                   out_last
);
  import fqop_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  // Registers
  state_t          state_r,      state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [TS_W-1:0] latest_r,     latest_nxt;
  logic [CAP_W-1:0] capacity_r,  capacity_nxt;
  policy_t         policy_r,     policy_nxt;
  status_t         pend_status_r, pend_status_nxt;
  outcnt_t         pend_dropped_r, pend_dropped_nxt;
  logic            pend_fvalid_r, pend_fvalid_nxt;
  entry_t          pend_frame_r,  pend_frame_nxt;
  logic            pend_last_r,   pend_last_nxt;
  logic            pend_drain_r,  pend_drain_nxt;
  logic            out_valid_r,   out_valid_nxt;
  status_t         out_status_r,  out_status_nxt;
  outcnt_t         out_dropped_r, out_dropped_nxt;
  logic            out_fvalid_r,  out_fvalid_nxt;
  entry_t          out_frame_r,   out_frame_nxt;
  outcnt_t         out_depth_r,   out_depth_nxt;
  logic [63:0]     out_age_r,     out_age_nxt;
  logic            out_last_r,    out_last_nxt;

  // Cell row signals
  entry_t          cells   [DEPTH];
  cell_ctrl_t      cell_ctrl [DEPTH];
  entry_t          load_entry;
  logic            row_shift;
  logic            row_load;
  logic [IDX_W-1:0] load_idx;

  // Decode helpers
  logic             in_accept;
  logic             slot_free;
  logic             frame_ok;
  logic [CNT_W-1:0] cap_eff;
  logic [63:0]      head_age;

  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  // Incoming frame as it would be stored.
  always_comb begin
    load_entry.handle      = in_frame_handle;
    load_entry.width       = in_frame_width;
    load_entry.height      = in_frame_height;
    load_entry.timestamp   = in_frame_timestamp[TS_W-1:0];
    load_entry.queued_time = in_queued_time;
  end

  assign frame_ok = (in_frame_handle != 32'd0) && (in_frame_width != 16'd0) &&
                    (in_frame_height != 16'd0) && !in_frame_timestamp[63];

  // Capacity above the cell count acts as the cell count.
  always_comb begin
    if (CMP_W'(capacity_r) > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
  end

  // Age of the head entry against the latest timestamp seen.
  always_comb begin
    if (count_r == '0) begin
      head_age = 64'd0;
    end else if (latest_r >= cells[0].timestamp) begin
      head_age = {1'b0, latest_r - cells[0].timestamp};
    end else begin
      head_age = 64'd0;
    end
  end

  // Queue controller
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    latest_nxt       = latest_r;
    capacity_nxt     = capacity_r;
    policy_nxt       = policy_r;
    pend_status_nxt  = pend_status_r;
    pend_dropped_nxt = pend_dropped_r;
    pend_fvalid_nxt  = pend_fvalid_r;
    pend_frame_nxt   = pend_frame_r;
    pend_last_nxt    = pend_last_r;
    pend_drain_nxt   = pend_drain_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_dropped_nxt  = out_dropped_r;
    out_fvalid_nxt   = out_fvalid_r;
    out_frame_nxt    = out_frame_r;
    out_depth_nxt    = out_depth_r;
    out_age_nxt      = out_age_r;
    out_last_nxt     = out_last_r;
    row_shift        = 1'b0;
    row_load         = 1'b0;
    load_idx         = count_r[IDX_W-1:0];

    // Configuration writes.
    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CAPACITY: capacity_nxt = cfg_data;
        REG_POLICY:   policy_nxt   = policy_t'(cfg_data[POL_W-1:0]);
        default:      capacity_nxt = capacity_r;
      endcase
    end

    // The output register empties when its beat is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt        = S_EMIT;
          pend_dropped_nxt = '0;
          pend_fvalid_nxt  = 1'b0;
          pend_frame_nxt   = '0;
          pend_last_nxt    = 1'b1;
          pend_drain_nxt   = 1'b0;
          case (op_t'(in_operation))
            OP_PUSH: begin
              if (cap_eff == '0) begin
                pend_status_nxt = ST_BAD_CONFIG;
              end else if (!frame_ok) begin
                pend_status_nxt = ST_BAD_FRAME;
              end else begin
                if (in_frame_timestamp[TS_W-1:0] > latest_r) begin
                  latest_nxt = in_frame_timestamp[TS_W-1:0];
                end
                if (count_r < cap_eff) begin
                  row_load        = 1'b1;
                  load_idx        = count_r[IDX_W-1:0];
                  count_nxt       = count_r + 1'b1;
                  pend_status_nxt = ST_QUEUED;
                end else if (policy_r == POL_DROP_NEW) begin
                  pend_status_nxt  = ST_DROPPED_NEW;
                  pend_dropped_nxt = outcnt_t'(1);
                end else if (policy_r == POL_DROP_BACKLOG) begin
                  row_load         = 1'b1;
                  load_idx         = '0;
                  count_nxt        = CNT_W'(1);
                  pend_status_nxt  = ST_DROPPED_BACKLOG;
                  pend_dropped_nxt = outcnt_t'(count_r);
                end else begin
                  // Drop oldest: shift the row and put the frame at the tail.
                  row_shift        = 1'b1;
                  row_load         = 1'b1;
                  load_idx         = IDX_W'(count_r - 1'b1);
                  pend_status_nxt  = ST_DROPPED_OLDEST;
                  pend_dropped_nxt = outcnt_t'(1);
                end
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                pend_status_nxt = ST_EMPTY;
              end else begin
                pend_status_nxt = ST_POPPED;
                pend_fvalid_nxt = 1'b1;
                pend_frame_nxt  = cells[0];
                row_shift       = 1'b1;
                count_nxt       = count_r - 1'b1;
              end
            end
            OP_DRAIN: begin
              pend_status_nxt = ST_DRAINED;
              if (count_r != '0) begin
                pend_fvalid_nxt = 1'b1;
                pend_frame_nxt  = cells[0];
                pend_last_nxt   = (count_r == CNT_W'(1));
                pend_drain_nxt  = 1'b1;
                row_shift       = 1'b1;
                count_nxt       = count_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              pend_status_nxt  = ST_CLEARED;
              pend_dropped_nxt = outcnt_t'(count_r);
              count_nxt        = '0;
            end
            default: pend_status_nxt = ST_EMPTY;
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          // Result beat reports the queue as it stands now.
          out_valid_nxt   = 1'b1;
          out_status_nxt  = pend_status_r;
          out_dropped_nxt = pend_dropped_r;
          out_fvalid_nxt  = pend_fvalid_r;
          out_frame_nxt   = pend_frame_r;
          out_depth_nxt   = outcnt_t'(count_r);
          out_age_nxt     = head_age;
          out_last_nxt    = pend_last_r;
          if (pend_drain_r && !pend_last_r) begin
            // Take the next head for the following drain beat.
            pend_frame_nxt = cells[0];
            pend_last_nxt  = (count_r == CNT_W'(1));
            row_shift      = 1'b1;
            count_nxt      = count_r - 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      latest_r    <= '0;
      capacity_r  <= CAP_W'(DEPTH);
      policy_r    <= POL_DROP_OLDEST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      latest_r    <= latest_nxt;
      capacity_r  <= capacity_nxt;
      policy_r    <= policy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and pending result, no reset needed.
  always_ff @(posedge clk) begin
    pend_status_r  <= pend_status_nxt;
    pend_dropped_r <= pend_dropped_nxt;
    pend_fvalid_r  <= pend_fvalid_nxt;
    pend_frame_r   <= pend_frame_nxt;
    pend_last_r    <= pend_last_nxt;
    pend_drain_r   <= pend_drain_nxt;
    out_status_r   <= out_status_nxt;
    out_dropped_r  <= out_dropped_nxt;
    out_fvalid_r   <= out_fvalid_nxt;
    out_frame_r    <= out_frame_nxt;
    out_depth_r    <= out_depth_nxt;
    out_age_r      <= out_age_nxt;
    out_last_r     <= out_last_nxt;
  end

  // Row of cells, head in cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == DEPTH - 1) begin : g_tail
      assign nbr = load_entry;
    end else begin : g_mid
      assign nbr = cells[i+1];
    end

    assign cell_ctrl[i].shift = row_shift;
    assign cell_ctrl[i].load  = row_load && (load_idx == IDX_W'(i));

    fqop_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .nbr_entry  (nbr),
      .load_entry (load_entry),
      .entry      (cells[i])
    );
  end

  // Output ports.
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_dropped_count = out_dropped_r;
  assign out_frame_valid   = out_fvalid_r;
  assign out_handle        = out_frame_r.handle;
  assign out_width         = out_frame_r.width;
  assign out_height        = out_frame_r.height;
  assign out_timestamp     = out_frame_r.timestamp;
  assign out_queued_time   = out_frame_r.queued_time;
  assign out_depth         = out_depth_r;
  assign out_oldest_age    = out_age_r;
  assign out_last          = out_last_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds the number of cells");

  a_latest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> latest_r >= $past(latest_r))
    else $error("latest seen timestamp went backwards");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_operation == OP_CLEAR) |=> count_r == '0)
    else $error("clear left entries in the queue");

  a_pop_removes: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_operation == OP_POP) && (count_r != '0)
    |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not remove exactly one entry");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fvalid_r |-> out_frame_r == '0)
    else $error("result without a frame carries frame data");

endmodule
